// ===== hw/rtl/go_to_goal_steering_macros.svh =====
// Assertion macros for the go-to-goal steering block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GO_TO_GOAL_STEERING_MACROS_SVH
`define GO_TO_GOAL_STEERING_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GGS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define GGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ggs_pkg.sv =====
// Shared types, constants and functions for the go-to-goal steering block.
// No dependencies.
`default_nettype none
package ggs_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int GUARD = 8;
	localparam int QW = 35;   // quaternion sums
	localparam int CW = 46;   // CORDIC lane width
	localparam int AW = 32;   // binary angle width
	localparam logic [15:0] INV_HI = 16'd39796;
	localparam logic [15:0] INV_LO = 16'd60840;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_ROTATE  = 2'd0,
		ST_DRIVE   = 2'd1,
		ST_REACHED = 2'd2,
		ST_CANCEL  = 2'd3
	} ggs_status_t;

	typedef enum logic [2:0] {
		REG_GOAL_X    = 3'd0,
		REG_GOAL_Y    = 3'd1,
		REG_ARRIVE    = 3'd2,
		REG_TURN      = 3'd3,
		REG_ANG_GAIN  = 3'd4,
		REG_LIN_GAIN  = 3'd5,
		REG_MAX_LIN   = 3'd6
	} ggs_reg_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [AW-1:0] ang;
	} ggs_vec_t;

	typedef struct packed {
		logic cancel;
		logic gimbal;
	} ggs_side_t;

	function automatic logic [AW-1:0] atan_ent(input int unsigned i);
		logic [AW-1:0] r;
		case (i)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// scale up by the guard bits and fold the left half plane
	function automatic ggs_vec_t pre_rot(input logic signed [CW-1:0] x0,
			input logic signed [CW-1:0] y0);
		ggs_vec_t v;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		x = x0 <<< GUARD;
		y = y0 <<< GUARD;
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.ang = HALF_TURN;
		end else begin
			v.x = x;
			v.y = y;
			v.ang = '0;
		end
		return v;
	endfunction

	function automatic ggs_vec_t cordic_step(input ggs_vec_t v, input int unsigned i);
		ggs_vec_t r;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		x = v.x;
		y = v.y;
		xs = x >>> i;
		ys = y >>> i;
		if (y >= 0) begin
			r.x = x + ys;
			r.y = y - xs;
			r.ang = v.ang + atan_ent(i);
		end else begin
			r.x = x - ys;
			r.y = y + xs;
			r.ang = v.ang - atan_ent(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ggs_front.sv =====
// Front end: quaternion products, yaw operands, gimbal check, goal offset.
// Three stages; uses ggs_pkg.
`default_nettype none
module ggs_front import ggs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               cancel,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [31:0] goal_x,
	input  wire logic signed [31:0] goal_y,
	output logic                    out_valid,
	output ggs_side_t               out_side,
	output ggs_vec_t                yaw_vec,
	output ggs_vec_t                brg_vec
);

	logic v_s1, v_s2, v_s3;
	logic cancel_s1, cancel_s2;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, xz_s1, wy_s1, wz_s1, xy_s1;
	logic signed [32:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [QW-1:0] norm_s2, tilt_s2, num_s2, den_s2;
	logic signed [QW-1:0] tilt_abs;
	ggs_side_t side_s3;
	ggs_vec_t  yaw_s3, brg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cancel_s1 <= cancel;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			ww_s1 <= quat_w * quat_w;
			xz_s1 <= quat_x * quat_z;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			dx_s1 <= 33'(goal_x) - 33'(pos_x);
			dy_s1 <= 33'(goal_y) - 33'(pos_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cancel_s2 <= cancel_s1;
			norm_s2 <= QW'(xx_s1) + QW'(yy_s1) + QW'(zz_s1) + QW'(ww_s1);
			tilt_s2 <= (QW'(xz_s1) - QW'(wy_s1)) <<< 1;
			num_s2 <= (QW'(wz_s1) + QW'(xy_s1)) <<< 1;
			den_s2 <= QW'(ww_s1) + QW'(xx_s1) - QW'(yy_s1) - QW'(zz_s1);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	assign tilt_abs = (tilt_s2 < 0) ? -tilt_s2 : tilt_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.cancel <= cancel_s2;
			side_s3.gimbal <= (tilt_abs >= norm_s2);
			yaw_s3 <= pre_rot(CW'(den_s2), CW'(num_s2));
			brg_s3 <= pre_rot(CW'(dx_s2), CW'(dy_s2));
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign yaw_vec   = yaw_s3;
	assign brg_vec   = brg_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/ggs_cordic.sv =====
// Unrolled vectoring CORDIC, two lanes (yaw and bearing) in lockstep.
// One register stage per iteration; uses ggs_pkg.
`default_nettype none
module ggs_cordic import ggs_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire ggs_side_t in_side,
	input  wire ggs_vec_t  yaw_in,
	input  wire ggs_vec_t  brg_in,
	output logic           out_valid,
	output ggs_side_t      out_side,
	output ggs_vec_t       yaw_out,
	output ggs_vec_t       brg_out
);

	logic      v_stg    [0:STAGES];
	ggs_side_t side_stg [0:STAGES];
	ggs_vec_t  yaw_stg  [0:STAGES];
	ggs_vec_t  brg_stg  [0:STAGES];

	assign v_stg[0]    = in_valid;
	assign side_stg[0] = in_side;
	assign yaw_stg[0]  = yaw_in;
	assign brg_stg[0]  = brg_in;

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_stg[i+1] <= 1'b0;
			end else if (en) begin
				v_stg[i+1] <= v_stg[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_stg[i+1] <= side_stg[i];
				yaw_stg[i+1]  <= cordic_step(yaw_stg[i], i);
				brg_stg[i+1]  <= cordic_step(brg_stg[i], i);
			end
		end
	end

	assign out_valid = v_stg[STAGES];
	assign out_side  = side_stg[STAGES];
	assign yaw_out   = yaw_stg[STAGES];
	assign brg_out   = brg_stg[STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/ggs_post.sv =====
// Back end: distance scaling, heading error, gains, limits and status.
// Four stages, the last is the output register; uses ggs_pkg.
`default_nettype none
module ggs_post import ggs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire ggs_side_t   in_side,
	input  wire ggs_vec_t    yaw_vec,
	input  wire ggs_vec_t    brg_vec,
	input  wire logic [31:0] arrive_radius,
	input  wire logic [14:0] turn_threshold,
	input  wire logic [15:0] angular_gain,
	input  wire logic [15:0] linear_gain,
	input  wire logic [31:0] max_linear,
	output logic             out_valid,
	output logic [31:0]      linear_cmd,
	output logic [31:0]      angular_cmd,
	output logic [31:0]      distance_left,
	output logic [15:0]      heading_error,
	output ggs_status_t      status
);

	localparam int MW  = CW - 1;
	localparam int PW  = MW + 16;
	localparam int EPW = 65;
	localparam logic signed [EPW-1:0] E_RND = {{(EPW-48){1'b0}}, 1'b1, 47'b0};
	localparam logic [PW:0] D_RND = (PW+1)'(1) << (15 + GUARD);

	logic v_s1, v_s2, v_s3, v_s4;
	logic cancel_s1, cancel_s2, cancel_s3;
	logic signed [CW-1:0] bx;
	logic [MW-1:0] mag;
	logic [AW-1:0] err;
	logic [PW-1:0] phi_s1, plo_s1;
	logic signed [EPW-1:0] eprod_s1;
	logic [PW:0] dsum;
	logic [PW-GUARD-16:0] dfull;
	logic signed [EPW-1:0] eadd;
	logic [31:0] dist_s2, dist_s3;
	logic signed [15:0] eq13_s2, eq13_s3;
	logic signed [16:0] eabs;
	logic signed [32:0] aprod_s3;
	logic [47:0] lprod_s3;
	logic reached_s3, turn_s3;
	logic signed [32:0] ang_r;
	logic [39:0] lin_raw;
	logic [31:0] lin_cap;
	logic [31:0] lin_s4, ang_s4, dist_s4;
	logic [15:0] eq13_s4;
	ggs_status_t st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: scale magnitude, multiply heading error by one turn
	assign bx  = brg_vec.x;
	assign mag = (bx > 0) ? bx[MW-1:0] : '0;
	assign err = brg_vec.ang - (in_side.gimbal ? '0 : yaw_vec.ang);

	always_ff @(posedge clk) begin
		if (en) begin
			cancel_s1 <= in_side.cancel;
			phi_s1 <= PW'(mag) * PW'(INV_HI);
			plo_s1 <= PW'(mag) * PW'(INV_LO);
			eprod_s1 <= EPW'($signed(err)) * EPW'($signed({1'b0, TWO_PI_Q29}));
		end
	end

	// stage 2: round distance and error
	assign dsum  = (PW+1)'(phi_s1) + (PW+1)'(plo_s1 >> 16) + D_RND;
	assign dfull = dsum[PW:GUARD+16];
	assign eadd  = eprod_s1 + E_RND;

	always_ff @(posedge clk) begin
		if (en) begin
			cancel_s2 <= cancel_s1;
			dist_s2 <= (|dfull[PW-GUARD-16:32]) ? 32'hFFFF_FFFF : dfull[31:0];
			eq13_s2 <= eadd[63:48];
		end
	end

	// stage 3: gains and decisions
	assign eabs = (eq13_s2 < 0) ? -17'(eq13_s2) : 17'(eq13_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			cancel_s3  <= cancel_s2;
			dist_s3    <= dist_s2;
			eq13_s3    <= eq13_s2;
			aprod_s3   <= $signed({17'b0, angular_gain}) * 33'(eq13_s2);
			lprod_s3   <= 48'(linear_gain) * 48'(dist_s2);
			reached_s3 <= (dist_s2 < arrive_radius);
			turn_s3    <= (eabs > $signed({2'b0, turn_threshold}));
		end
	end

	// stage 4: round, cap, pick status
	assign ang_r   = (aprod_s3 + 33'sd16) >>> 5;
	assign lin_raw = 40'((lprod_s3 + 48'd128) >> 8);
	assign lin_cap = (lin_raw > 40'(max_linear)) ? max_linear : lin_raw[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (cancel_s3) begin
				lin_s4  <= '0;
				ang_s4  <= '0;
				dist_s4 <= '0;
				eq13_s4 <= '0;
				st_s4   <= ST_CANCEL;
			end else begin
				dist_s4 <= dist_s3;
				eq13_s4 <= eq13_s3;
				if (reached_s3) begin
					lin_s4 <= '0;
					ang_s4 <= '0;
					st_s4  <= ST_REACHED;
				end else if (turn_s3) begin
					lin_s4 <= '0;
					ang_s4 <= ang_r[31:0];
					st_s4  <= ST_ROTATE;
				end else begin
					lin_s4 <= lin_cap;
					ang_s4 <= ang_r[31:0];
					st_s4  <= ST_DRIVE;
				end
			end
		end
	end

	assign out_valid     = v_s4;
	assign linear_cmd    = lin_s4;
	assign angular_cmd   = ang_s4;
	assign distance_left = dist_s4;
	assign heading_error = eq13_s4;
	assign status        = st_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/go_to_goal_steering.sv =====
// Channel  | dir | payload
// s_axis   | in  | tdata: pos_x, pos_y, quat_x..quat_w; tuser: op
// m_axis   | out | tdata: linear_cmd, angular_cmd, distance_left, heading_error, status
// cfg      | in  | cfg_we, cfg_index, cfg_data
// One item enters per cycle while the output is not stalled; each item passes the front end,
// the unrolled CORDIC pipeline and the back end in that order.
// arst_n clears valid bits and loads register defaults.
// When the output holds a transfer that is not taken, the whole pipeline stalls.
// Top level of the go-to-goal steering block; uses ggs_pkg, ggs_front, ggs_cordic,
// ggs_post and the assertion macros header.
`default_nettype none
`include "go_to_goal_steering_macros.svh"
module go_to_goal_steering import ggs_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80], quat_z[111:96], quat_w[127:112]
	input  wire logic [127:0] s_axis_tdata,
	// op[0]
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// linear_cmd[31:0], angular_cmd[63:32], distance_left[95:64], heading_error[111:96],
	// status[113:112], zero[119:114]
	output logic [119:0]      m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	logic [31:0] goal_x_q, goal_y_q, arrive_q, max_lin_q;
	logic [14:0] turn_q;
	logic [15:0] ang_gain_q, lin_gain_q;
	logic adv;
	logic f_valid, c_valid;
	ggs_side_t f_side, c_side;
	ggs_vec_t f_yaw, f_brg, c_yaw, c_brg;
	logic [31:0] linear_cmd, angular_cmd, distance_left;
	logic [15:0] heading_error;
	ggs_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			arrive_q   <= 32'd6554;
			turn_q     <= 15'd1638;
			ang_gain_q <= 16'd128;
			lin_gain_q <= 16'd77;
			max_lin_q  <= 32'd32768;
		end else if (cfg_we) begin
			case (ggs_reg_t'(cfg_index))
				REG_GOAL_X:   goal_x_q   <= cfg_data;
				REG_GOAL_Y:   goal_y_q   <= cfg_data;
				REG_ARRIVE:   arrive_q   <= cfg_data;
				REG_TURN:     turn_q     <= cfg_data[14:0];
				REG_ANG_GAIN: ang_gain_q <= cfg_data[15:0];
				REG_LIN_GAIN: lin_gain_q <= cfg_data[15:0];
				REG_MAX_LIN:  max_lin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance everything unless a finished result is held
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	ggs_front u_front (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(s_axis_tvalid), .cancel(s_axis_tuser),
		.pos_x(s_axis_tdata[31:0]), .pos_y(s_axis_tdata[63:32]),
		.quat_x(s_axis_tdata[79:64]), .quat_y(s_axis_tdata[95:80]),
		.quat_z(s_axis_tdata[111:96]), .quat_w(s_axis_tdata[127:112]),
		.goal_x(goal_x_q), .goal_y(goal_y_q),
		.out_valid(f_valid), .out_side(f_side), .yaw_vec(f_yaw), .brg_vec(f_brg)
	);

	ggs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(f_valid), .in_side(f_side), .yaw_in(f_yaw), .brg_in(f_brg),
		.out_valid(c_valid), .out_side(c_side), .yaw_out(c_yaw), .brg_out(c_brg)
	);

	ggs_post u_post (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(c_valid), .in_side(c_side), .yaw_vec(c_yaw), .brg_vec(c_brg),
		.arrive_radius(arrive_q), .turn_threshold(turn_q),
		.angular_gain(ang_gain_q), .linear_gain(lin_gain_q), .max_linear(max_lin_q),
		.out_valid(m_axis_tvalid), .linear_cmd(linear_cmd), .angular_cmd(angular_cmd),
		.distance_left(distance_left), .heading_error(heading_error), .status(status)
	);

	assign m_axis_tdata = {6'b0, status, heading_error, distance_left, angular_cmd,
		linear_cmd};

	`GGS_ASSERT_NOW(a_cancel_zero, m_axis_tvalid && status == ST_CANCEL, linear_cmd == '0 && angular_cmd == '0 && distance_left == '0, "cancel result not zero")
	`GGS_ASSERT_NOW(a_reached_stop, m_axis_tvalid && status == ST_REACHED, linear_cmd == '0 && angular_cmd == '0, "reached but commands nonzero")
	`GGS_ASSERT_NOW(a_rotate_still, m_axis_tvalid && status == ST_ROTATE, linear_cmd == '0, "rotating with forward speed")
	`GGS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule
`default_nettype wire
